@@ design/ppt_pkg.sv @@
// ----------------------------------------------------------------------------
// Parent pointer tree table package
// Shared codes and field widths for the parent pointer tree table unit.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int unsigned FieldW = 5;

  typedef logic [1:0]        op_t;
  typedef logic [FieldW-1:0] node_t;
  typedef logic signed [FieldW-1:0] entry_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_CLEAR  = 2'd1;
  localparam op_t OP_QUERY  = 2'd2;

  localparam entry_t EMPTY_CODE = -5'sd2;
  localparam entry_t ROOT_CODE  = -5'sd1;

endpackage

@@ design/parent_pointer_tree_table_unit.sv @@
// Insert, clear and unused words are accepted while idle; ready stays high.
// A query holds ready low while it scans the table, one entry a cycle, and
// then passes the last and done states; the next word is taken back in idle.
// The result word is held in an output register until taken; a word still
// waiting there holds the next query back.
// Reset empties the table at once through per-entry valid bits.
// ----------------------------------------------------------------------------
// Parent pointer tree table unit
// Table of parent pointers with insert, clear and a scanning query that
// reports parent, first child and next sibling of a node and the first root entry.
// ----------------------------------------------------------------------------
module parent_pointer_tree_table_unit #(
  parameter int unsigned NODE_COUNT = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  ppt_pkg::op_t            op_i,
  input  ppt_pkg::node_t          node_i,
  input  ppt_pkg::entry_t         new_parent_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output ppt_pkg::entry_t         parent_of_node_o,
  output ppt_pkg::entry_t         first_child_o,
  output ppt_pkg::entry_t         next_sibling_o,
  output ppt_pkg::entry_t         root_node_o
);

  localparam int unsigned IdxW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam ppt_pkg::node_t NodeLim = ppt_pkg::node_t'(NODE_COUNT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } state_e;

  state_e state_q;

  ppt_pkg::entry_t mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] valid_q;

  logic [IdxW-1:0] cnt_q;
  logic [IdxW-1:0] rd_idx_q;
  ppt_pkg::entry_t rd_q;
  logic            rd_ok_q;
  logic            rd_vld_q;
  ppt_pkg::node_t  node_q;

  ppt_pkg::entry_t par_q, lc_q, rs_q, rt_q;
  logic            lc_fnd_q, rs_fnd_q, rt_fnd_q;

  logic            out_valid_q;
  ppt_pkg::entry_t par_out_q, lc_out_q, rs_out_q, rt_out_q;

  logic            in_fire;
  logic            wr_en;
  ppt_pkg::entry_t ent;
  ppt_pkg::node_t  rd_node;
  ppt_pkg::entry_t rd_idx_s;
  logic            hit_node, hit_child, hit_sib, hit_root;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign wr_en      = in_fire && (op_i == ppt_pkg::OP_INSERT) && (node_i < NodeLim);

  assign ent       = rd_ok_q ? rd_q : ppt_pkg::EMPTY_CODE;
  assign rd_node   = ppt_pkg::node_t'(rd_idx_q);
  assign rd_idx_s  = ppt_pkg::entry_t'(rd_idx_q);
  assign hit_node  = rd_vld_q && (rd_node == node_q);
  assign hit_child = rd_vld_q && !lc_fnd_q && ({ent[4], ent} == {1'b0, node_q});
  assign hit_sib   = rd_vld_q && !rs_fnd_q && (rd_node > node_q) && (ent == par_q);
  assign hit_root  = rd_vld_q && !rt_fnd_q && (ent == ppt_pkg::ROOT_CODE);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[node_i[IdxW-1:0]] <= new_parent_i;
    end
    rd_q <= mem[cnt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      rd_ok_q <= valid_q[cnt_q];
      if (in_fire && (op_i == ppt_pkg::OP_CLEAR)) begin
        valid_q <= '0;
      end else if (wr_en) begin
        valid_q[node_i[IdxW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      node_q      <= '0;
      par_q       <= ppt_pkg::EMPTY_CODE;
      lc_q        <= ppt_pkg::EMPTY_CODE;
      rs_q        <= ppt_pkg::EMPTY_CODE;
      rt_q        <= ppt_pkg::EMPTY_CODE;
      lc_fnd_q    <= 1'b0;
      rs_fnd_q    <= 1'b0;
      rt_fnd_q    <= 1'b0;
      out_valid_q <= 1'b0;
      par_out_q   <= ppt_pkg::EMPTY_CODE;
      lc_out_q    <= ppt_pkg::EMPTY_CODE;
      rs_out_q    <= ppt_pkg::EMPTY_CODE;
      rt_out_q    <= ppt_pkg::EMPTY_CODE;
    end else begin
      rd_vld_q <= (state_q == ST_SCAN);
      rd_idx_q <= cnt_q;
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      if (hit_node) begin
        par_q <= ent;
      end
      if (hit_child) begin
        lc_q     <= rd_idx_s;
        lc_fnd_q <= 1'b1;
      end
      if (hit_sib) begin
        rs_q     <= rd_idx_s;
        rs_fnd_q <= 1'b1;
      end
      if (hit_root) begin
        rt_q     <= rd_idx_s;
        rt_fnd_q <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (in_fire && (op_i == ppt_pkg::OP_QUERY)) begin
            node_q   <= node_i;
            par_q    <= ppt_pkg::EMPTY_CODE;
            lc_q     <= ppt_pkg::EMPTY_CODE;
            rs_q     <= ppt_pkg::EMPTY_CODE;
            rt_q     <= ppt_pkg::EMPTY_CODE;
            lc_fnd_q <= 1'b0;
            rs_fnd_q <= 1'b0;
            rt_fnd_q <= 1'b0;
            state_q  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt_q == IdxW'(NODE_COUNT - 1)) begin
            state_q <= ST_LAST;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_LAST: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            par_out_q   <= par_q;
            lc_out_q    <= lc_q;
            rs_out_q    <= rs_q;
            rt_out_q    <= rt_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign parent_of_node_o = par_out_q;
  assign first_child_o    = lc_out_q;
  assign next_sibling_o   = rs_out_q;
  assign root_node_o      = rt_out_q;

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op_i == ppt_pkg::OP_QUERY)) |=> !in_ready_o)
    else $error("ready still high after query accept");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op_i == ppt_pkg::OP_CLEAR)) |=> (valid_q == '0))
    else $error("clear left valid entries");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((root_node_o == ppt_pkg::EMPTY_CODE) ||
                     (!root_node_o[4] && (ppt_pkg::node_t'(root_node_o) < NodeLim))))
    else $error("root index out of range");

  a_child_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((first_child_o == ppt_pkg::EMPTY_CODE) ||
                     (!first_child_o[4] &&
                      (ppt_pkg::node_t'(first_child_o) < NodeLim))))
    else $error("child index out of range");

  a_sib_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((next_sibling_o == ppt_pkg::EMPTY_CODE) ||
                     (!next_sibling_o[4] &&
                      (ppt_pkg::node_t'(next_sibling_o) < NodeLim))))
    else $error("sibling index out of range");

endmodule

@@ tb/parent_pointer_tree_table_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Parent pointer tree table unit testbench
// Drives insert, clear, query and unused words through the input handshake, mirrors
// the parent table locally and checks every query answer field by field,
// with random idle cycles on the input and output channels, bar a gap-free stretch.
// ----------------------------------------------------------------------------
module parent_pointer_tree_table_unit_tb;

  localparam int unsigned NodeCount   = 16;
  localparam int unsigned IdxW        = $clog2(NodeCount);
  localparam int unsigned IdlePct     = 26;
  localparam int unsigned RandomWords = 1025;
  localparam ppt_pkg::op_t OpUnused   = 2'd3;

  typedef struct {
    ppt_pkg::entry_t parent;
    ppt_pkg::entry_t child;
    ppt_pkg::entry_t sibling;
    ppt_pkg::entry_t root;
  } answer_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  ppt_pkg::op_t     op_i;
  ppt_pkg::node_t   node_i;
  ppt_pkg::entry_t  new_parent_i;
  logic             out_valid_o;
  logic             out_ready_i;
  ppt_pkg::entry_t  parent_of_node_o;
  ppt_pkg::entry_t  first_child_o;
  ppt_pkg::entry_t  next_sibling_o;
  ppt_pkg::entry_t  root_node_o;

  ppt_pkg::entry_t tree_table [NodeCount];
  answer_t         pending_answers [$];
  int unsigned     error_count = 0;
  bit              no_gaps;

  parent_pointer_tree_table_unit #(
    .NODE_COUNT(NodeCount)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .node_i          (node_i),
    .new_parent_i    (new_parent_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .parent_of_node_o(parent_of_node_o),
    .first_child_o   (first_child_o),
    .next_sibling_o  (next_sibling_o),
    .root_node_o     (root_node_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic ppt_pkg::entry_t find_entry(int unsigned start, int want);
    for (int unsigned i = start; i < NodeCount; i++) begin
      if (int'(tree_table[i[IdxW-1:0]]) == want) return ppt_pkg::entry_t'(i);
    end
    return ppt_pkg::EMPTY_CODE;
  endfunction

  function automatic void apply_word(ppt_pkg::op_t op, ppt_pkg::node_t node,
                                     ppt_pkg::entry_t np);
    answer_t ans;
    bit      in_range;
    in_range = (node < NodeCount);
    case (op)
      ppt_pkg::OP_INSERT: begin
        if (in_range) tree_table[node[IdxW-1:0]] = np;
      end
      ppt_pkg::OP_CLEAR: begin
        foreach (tree_table[i]) tree_table[i] = ppt_pkg::EMPTY_CODE;
      end
      ppt_pkg::OP_QUERY: begin
        ans.parent  = in_range ? tree_table[node[IdxW-1:0]] : ppt_pkg::EMPTY_CODE;
        ans.child   = find_entry(0, int'(node));
        ans.sibling = in_range ? find_entry(node + 1, int'(ans.parent))
                               : ppt_pkg::EMPTY_CODE;
        ans.root    = find_entry(0, int'(ppt_pkg::ROOT_CODE));
        pending_answers.push_back(ans);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_field(string name, ppt_pkg::entry_t want,
                                      ppt_pkg::entry_t got);
    if (got !== want) begin
      error_count++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  task automatic send_word(ppt_pkg::op_t op, ppt_pkg::node_t node, ppt_pkg::entry_t np);
    while (!no_gaps && $urandom_range(99, 0) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    node_i       <= node;
    new_parent_i <= np;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_word(op, node, np);
  endtask

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        error_count++;
        $error("result word with no query pending");
      end else begin
        want = pending_answers.pop_front();
        check_field("parent_of_node", want.parent, parent_of_node_o);
        check_field("first_child", want.child, first_child_o);
        check_field("next_sibling", want.sibling, next_sibling_o);
        check_field("root_node", want.root, root_node_o);
      end
    end
    out_ready_i <= no_gaps || ($urandom_range(99, 0) >= IdlePct);
  end

  task automatic test_empty_table();
    send_word(ppt_pkg::OP_QUERY, 5'd0, ppt_pkg::EMPTY_CODE);
    send_word(ppt_pkg::OP_QUERY, 5'd31, ppt_pkg::entry_t'(15));
  endtask

  task automatic test_basic_tree();
    send_word(ppt_pkg::OP_INSERT, 5'd0, ppt_pkg::ROOT_CODE);
    send_word(ppt_pkg::OP_INSERT, 5'd1, ppt_pkg::entry_t'(0));
    send_word(ppt_pkg::OP_INSERT, 5'd2, ppt_pkg::entry_t'(0));
    send_word(ppt_pkg::OP_INSERT, 5'd15, ppt_pkg::entry_t'(2));
    send_word(ppt_pkg::OP_QUERY, 5'd0, ppt_pkg::EMPTY_CODE);
    send_word(ppt_pkg::OP_QUERY, 5'd2, ppt_pkg::EMPTY_CODE);
    send_word(ppt_pkg::OP_QUERY, 5'd1, ppt_pkg::EMPTY_CODE);
    send_word(ppt_pkg::OP_QUERY, 5'd15, ppt_pkg::EMPTY_CODE);
  endtask

  task automatic test_out_of_range();
    send_word(ppt_pkg::OP_INSERT, 5'd16, ppt_pkg::ROOT_CODE);
    send_word(ppt_pkg::OP_INSERT, 5'd31, ppt_pkg::entry_t'(0));
    send_word(ppt_pkg::OP_QUERY, 5'd16, ppt_pkg::EMPTY_CODE);
    send_word(ppt_pkg::OP_QUERY, 5'd31, ppt_pkg::EMPTY_CODE);
  endtask

  task automatic test_odd_values();
    send_word(ppt_pkg::OP_INSERT, 5'd3, ppt_pkg::entry_t'(-16));
    send_word(ppt_pkg::OP_INSERT, 5'd4, ppt_pkg::entry_t'(-16));
    send_word(ppt_pkg::OP_INSERT, 5'd5, ppt_pkg::entry_t'(-3));
    send_word(ppt_pkg::OP_QUERY, 5'd3, ppt_pkg::EMPTY_CODE);
    send_word(ppt_pkg::OP_QUERY, 5'd5, ppt_pkg::EMPTY_CODE);
  endtask

  task automatic test_sibling_roots();
    send_word(ppt_pkg::OP_INSERT, 5'd9, ppt_pkg::ROOT_CODE);
    send_word(ppt_pkg::OP_QUERY, 5'd0, ppt_pkg::EMPTY_CODE);
  endtask

  task automatic test_unused_op();
    send_word(OpUnused, 5'd0, ppt_pkg::EMPTY_CODE);
    send_word(ppt_pkg::OP_QUERY, 5'd0, ppt_pkg::entry_t'(-16));
  endtask

  task automatic test_clear();
    send_word(ppt_pkg::OP_CLEAR, 5'd31, ppt_pkg::entry_t'(-16));
    send_word(ppt_pkg::OP_QUERY, 5'd0, ppt_pkg::EMPTY_CODE);
  endtask

  task automatic test_random(int unsigned words);
    int unsigned     counted;
    int unsigned     pick;
    int unsigned     sel;
    ppt_pkg::op_t    op;
    ppt_pkg::node_t  node;
    ppt_pkg::entry_t np;
    counted = 0;
    while (counted < words) begin
      no_gaps = (counted >= 400 && counted < 600);
      pick    = $urandom_range(99, 0);
      node    = ppt_pkg::node_t'($urandom_range(NodeCount - 1, 0));
      np      = ppt_pkg::entry_t'($urandom);
      if (pick < 42) begin
        op  = ppt_pkg::OP_INSERT;
        sel = $urandom_range(9, 0);
        if (sel < 2) np = ppt_pkg::ROOT_CODE;
        else if (sel < 8) np = ppt_pkg::entry_t'($urandom_range(NodeCount - 1, 0));
        if ($urandom_range(9, 0) == 0) node = ppt_pkg::node_t'($urandom_range(31, NodeCount));
      end else if (pick < 94) begin
        op = ppt_pkg::OP_QUERY;
        if ($urandom_range(99, 0) < 15) node = ppt_pkg::node_t'($urandom);
      end else if (pick < 97) begin
        op   = ppt_pkg::OP_CLEAR;
        node = ppt_pkg::node_t'($urandom);
      end else begin
        op   = OpUnused;
        node = ppt_pkg::node_t'($urandom);
      end
      send_word(op, node, np);
      counted++;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    int unsigned guard;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    op_i         = ppt_pkg::OP_INSERT;
    node_i       = '0;
    new_parent_i = ppt_pkg::EMPTY_CODE;
    no_gaps      = 1'b0;
    foreach (tree_table[i]) tree_table[i] = ppt_pkg::EMPTY_CODE;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_basic_tree();
    test_out_of_range();
    test_odd_values();
    test_sibling_roots();
    test_unused_op();
    test_clear();
    test_random(RandomWords);
    in_valid_i <= 1'b0;

    guard = 0;
    while (pending_answers.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (NodeCount + 4) @(posedge clk_i);
    foreach (pending_answers[i]) begin
      $error("query answer never arrived");
    end

    if (error_count == 0 && pending_answers.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
